[hdl/shs_pkg.sv]
// Shared types and constants of the SHA-256 stream hasher.
package shs_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned WordBits   = 32;
    localparam int unsigned Words      = 8;
    localparam int unsigned LenOffset  = 56;

    localparam logic [7:0] PadMarker = 8'h80;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_FOLD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    typedef struct packed {
        logic init;
        logic load;
        logic step;
    } t_rctl;

    localparam logic [31:0] InitWords [Words] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

[hdl/shs_ram.sv]
// Generic simple dual-port RAM with registered read.
module shs_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/shs_round.sv]
// Compression round unit: working variables, message schedule window and one round.
module shs_round (
    input  logic               i_clk,
    input  shs_pkg::t_rctl     i_ctl,
    input  logic [7:0]         i_byte,
    input  logic [31:0]        i_hash [shs_pkg::Words],
    input  logic [31:0]        i_k,
    output logic [31:0]        o_work [shs_pkg::Words]
);

    logic [31:0]  r_v [shs_pkg::Words];
    logic [511:0] r_win;
    logic [31:0]  w0, w1, w9, w14, w_new, t1, t2;
    logic [31:0]  s0, s1, bs0, bs1, ch, maj;

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

    always_comb begin
        w0  = r_win[511:480];
        w1  = r_win[479:448];
        w9  = r_win[223:192];
        w14 = r_win[63:32];
        s0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
        s1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
        w_new = w0 + s0 + w9 + s1;
        bs1 = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        bs0 = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + bs1 + ch + i_k + w0;
        t2  = bs0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_v <= i_hash;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        // The window holds w[t..t+15]; the first byte loaded ends up most significant.
        if (i_ctl.load) begin
            r_win <= {r_win[503:0], i_byte};
        end else if (i_ctl.step) begin
            r_win <= {r_win[479:0], w_new};
        end
    end

    assign o_work = r_v;

endmodule

[hdl/sha256_stream_hasher.sv]
// SHA-256 stream hasher: one message byte per input transaction, digest as eight words.
//
// Input channel: i_in_valid / o_in_stall with i_req_type and i_data_byte. A transaction
// with i_req_type 0 appends i_data_byte; with i_req_type 1 it finishes the message.
// Output channel: o_out_valid / i_out_stall with o_digest_word, o_word_index and
// o_last_word. A finish yields eight transactions, word 0 first, the last one flagged.
// A byte that does not complete a block does not stall the input. A byte that
// completes a block keeps the input stalled while the 64 buffered bytes are read
// out of the block RAM into the schedule window, 64 rounds run through the single
// round unit and the result is added into the chaining words. A finish pushes 9 to
// 72 padding bytes, one per cycle outside compressions, and runs one or two
// compressions; the digest words then leave one per cycle while not stalled.
// While the receiver stalls, the current word is held and no input is taken.
// After the last word the chaining words, fill count and length return to their
// initial values. Synchronous active-low reset puts the block in the same state.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    shs_pkg::t_state r_state, n_state;
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [63:0] r_bits;
    logic [6:0]  r_cnt;
    logic        r_pad, r_mark, r_lph;
    logic [3:0]  r_lcnt;
    logic [2:0]  r_widx;
    logic [31:0] r_hash [shs_pkg::Words];

    logic        in_acc, out_acc, push, pad_done;
    logic [7:0]  push_byte, pad_byte, rd_byte;
    logic [31:0] work [shs_pkg::Words];
    shs_pkg::t_rctl rctl;

    assign in_acc  = (r_state == shs_pkg::S_IDLE) && i_in_valid;
    assign out_acc = (r_state == shs_pkg::S_OUT) && !i_out_stall;
    assign pad_done = (r_lcnt == 4'd8);

    always_comb begin
        if (!r_mark) begin
            pad_byte = shs_pkg::PadMarker;
        end else if (!r_lph && r_fill != 6'(shs_pkg::LenOffset)) begin
            pad_byte = 8'h00;
        end else begin
            pad_byte = r_bits[63:56];
        end
    end

    assign push = (in_acc && !i_req_type) || (r_state == shs_pkg::S_PAD);
    assign push_byte = (r_state == shs_pkg::S_PAD) ? pad_byte : i_data_byte;

    shs_ram #(
        .Width (8),
        .Depth (shs_pkg::BlockBytes)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_fill),
        .i_wdata (push_byte),
        .i_raddr (r_cnt[5:0]),
        .o_rdata (rd_byte)
    );

    always_comb begin
        rctl.init = (r_state == shs_pkg::S_LOAD) && (r_cnt == 7'd0);
        rctl.load = (r_state == shs_pkg::S_LOAD) && (r_cnt != 7'd0);
        rctl.step = (r_state == shs_pkg::S_ROUND);
    end

    shs_round u_round (
        .i_clk  (i_clk),
        .i_ctl  (rctl),
        .i_byte (rd_byte),
        .i_hash (r_hash),
        .i_k    (shs_pkg::RoundK[r_cnt[5:0]]),
        .o_work (work)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shs_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type) begin
                        n_state = shs_pkg::S_PAD;
                    end else if (r_fill == 6'(shs_pkg::BlockBytes - 1)) begin
                        n_state = shs_pkg::S_LOAD;
                    end
                end
            end
            shs_pkg::S_PAD: begin
                if (r_fill == 6'(shs_pkg::BlockBytes - 1)) begin
                    n_state = shs_pkg::S_LOAD;
                end
            end
            shs_pkg::S_LOAD: begin
                if (r_cnt == 7'(shs_pkg::BlockBytes)) begin
                    n_state = shs_pkg::S_ROUND;
                end
            end
            shs_pkg::S_ROUND: begin
                if (r_cnt == 7'd63) begin
                    n_state = shs_pkg::S_FOLD;
                end
            end
            shs_pkg::S_FOLD: begin
                if (r_pad && pad_done) begin
                    n_state = shs_pkg::S_OUT;
                end else if (r_pad) begin
                    n_state = shs_pkg::S_PAD;
                end else begin
                    n_state = shs_pkg::S_IDLE;
                end
            end
            shs_pkg::S_OUT: begin
                if (out_acc && r_widx == 3'd7) begin
                    n_state = shs_pkg::S_IDLE;
                end
            end
            default: n_state = shs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shs_pkg::S_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_pad   <= 1'b0;
            r_mark  <= 1'b0;
            r_lph   <= 1'b0;
            r_lcnt  <= '0;
            r_widx  <= '0;
            r_hash  <= shs_pkg::InitWords;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (in_acc && !i_req_type) begin
                r_len <= r_len + 64'd1;
            end
            if (in_acc && i_req_type) begin
                r_bits <= {r_len[60:0], 3'b000};
                r_pad  <= 1'b1;
                r_mark <= 1'b0;
                r_lph  <= 1'b0;
                r_lcnt <= '0;
            end
            if (r_state == shs_pkg::S_PAD) begin
                if (!r_mark) begin
                    r_mark <= 1'b1;
                end else if (r_lph || r_fill == 6'(shs_pkg::LenOffset)) begin
                    r_lph  <= 1'b1;
                    r_bits <= {r_bits[55:0], 8'h00};
                    r_lcnt <= r_lcnt + 4'd1;
                end
            end
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else if (r_state == shs_pkg::S_LOAD || r_state == shs_pkg::S_ROUND) begin
                r_cnt <= r_cnt + 7'd1;
            end
            if (r_state == shs_pkg::S_FOLD) begin
                for (int i = 0; i < shs_pkg::Words; i++) begin
                    r_hash[i] <= r_hash[i] + work[i];
                end
            end
            if (out_acc) begin
                r_widx <= r_widx + 3'd1;
                if (r_widx == 3'd7) begin
                    r_hash <= shs_pkg::InitWords;
                    r_fill <= '0;
                    r_len  <= '0;
                    r_pad  <= 1'b0;
                end
            end
        end
    end

    assign o_in_stall    = (r_state != shs_pkg::S_IDLE);
    assign o_out_valid   = (r_state == shs_pkg::S_OUT);
    assign o_digest_word = r_hash[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == 3'd7);

endmodule

[hdl/shs_checker.sv]
// Port-level assertions for the SHA-256 stream hasher, bound to the top level.
module shs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_req_type,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // A stalled digest word must hold its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_digest_word))
        else $error("digest word changed while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last flag does not match word index");

    // The digest words of one message leave back to back in index order.
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_word |=>
            o_out_valid && o_word_index == $past(o_word_index) + 3'd1)
        else $error("digest words not in sequence");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while the digest is delivered");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_req_type |=> o_in_stall && !o_out_valid)
        else $error("finish transaction did not start padding");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_req_type    (i_req_type),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);

[test/sha256_stream_hasher_tb.sv]
// Self-checking testbench of the SHA-256 stream hasher with a digest predictor.
`timescale 1ns / 100ps

class digest_scoreboard;
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [63:0] byte_count;
    logic [31:0] pend_word [$];
    logic [2:0]  pend_index [$];
    logic        pend_last [$];
    int unsigned mismatches;

    function new();
        restart();
        mismatches = 0;
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) begin
            chain[i] = shs_pkg::InitWords[i];
        end
        fill = 0;
        byte_count = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + shs_pkg::RoundK[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function void put_byte(logic [7:0] v);
        blk[fill] = v;
        fill = (fill + 1) % 64;
        if (fill == 0) compress();
    endfunction

    // Notes one accepted input transaction and queues any digest words it yields.
    function void note_input(logic req, logic [7:0] data);
        logic [63:0] bits;
        if (!req) begin
            put_byte(data);
            byte_count += 1;
            return;
        end
        bits = byte_count << 3;
        put_byte(shs_pkg::PadMarker);
        while (fill != shs_pkg::LenOffset) put_byte(8'h00);
        for (int i = 0; i < 8; i++) put_byte(bits[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++) begin
            pend_word.push_back(chain[i]);
            pend_index.push_back(3'(i));
            pend_last.push_back(i == 7);
        end
        restart();
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
        logic [31:0] ew;
        logic [2:0]  ei;
        logic        el;
        if (pend_word.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digest word %h index %0d", word, idx);
            return;
        end
        ew = pend_word.pop_front();
        ei = pend_index.pop_front();
        el = pend_last.pop_front();
        if (word !== ew || idx !== ei || last !== el) begin
            mismatches++;
            if (mismatches <= 10)
                $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                         ew, ei, el, word, idx, last);
        end
    endfunction

    function int pending();
        return pend_word.size();
    endfunction
endclass

module sha256_stream_hasher_tb;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_FINISH = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 1500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    digest_scoreboard board = new();
    int unsigned cycles = 0;
    int unsigned n_sent = 0;
    bit          idle_enable = 1'b1;

    sha256_stream_hasher DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) board.note_input(i_req_type, i_data_byte);
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_word(o_digest_word, o_word_index, o_last_word);
    end

    // Receiver stalls for a random count of cycles before taking each word.
    initial begin
        int unsigned hold;
        forever begin
            @(negedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                hold = idle_enable ? $urandom_range(0, 18) : 0;
                if (hold != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(negedge i_clk);
                end
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send(logic req, logic [7:0] data);
        int unsigned gap;
        gap = idle_enable ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(int unsigned len, bit pattern);
        for (int i = 0; i < len; i++) begin
            send(REQ_APPEND, pattern ? 8'(i) : 8'($urandom_range(0, 255)));
        end
        send(REQ_FINISH, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int unsigned len;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty message, "abc", data bits at both extremes, a finish with
        // stray data bits set, lengths on each side of the padding boundary and one full block.
        send(REQ_FINISH, 8'h00);
        send(REQ_APPEND, 8'h61); send(REQ_APPEND, 8'h62); send(REQ_APPEND, 8'h63);
        send(REQ_FINISH, 8'hff);
        send(REQ_APPEND, 8'h00); send(REQ_APPEND, 8'hff);
        send(REQ_APPEND, 8'h55); send(REQ_APPEND, 8'haa);
        send(REQ_FINISH, 8'h80);
        idle_enable = 1'b0;
        send_message(55, 1'b1);
        send_message(56, 1'b1);
        send_message(64, 1'b0);
        idle_enable = 1'b1;

        // Drain completely before continuing.
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);

        while (n_sent < 300) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
            if ($urandom_range(0, 5) == 0) idle_enable = 1'b0;
            else idle_enable = 1'b1;
            send_message(len, 1'b0);
        end
        i_in_valid <= 1'b0;

        while (board.pending() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        if (board.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
